@@ hdl/uil_pkg.sv @@
package uil_pkg;

  localparam logic [31:0] MAGIC_WORD      = 32'hdeadbeef;
  localparam logic [31:0] REQ_WORD        = MAGIC_WORD ^ 32'h1;
  localparam logic [31:0] ACK_WORD        = MAGIC_WORD ^ 32'h2;
  localparam logic [31:0] FAIL_WORD       = 32'h50505050;
  localparam logic [31:0] LOAD_BASE_RESET = 32'h00080000;
  localparam int          ADDR_WIDTH_DEFAULT = 32;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // what one accepted byte asks the emitter to send
  typedef enum logic [1:0] {
    BM_WORD,    // four transmit bytes, low first
    BM_SIZE,    // eight transmit bytes, low first
    BM_WRITE,   // one memory write
    BM_STATUS   // four transmit bytes, then the load status
  } burst_mode_t;

  typedef struct packed {
    burst_mode_t mode;
    logic [63:0] data;
    logic [31:0] addr;
    logic        ok;
  } burst_t;

endpackage

@@ hdl/uart_image_loader_handshake_top.sv @@
// Serial image loader front end. Each received byte (rx_byte) enters on the
// in_valid/in_stall channel; the results it causes leave one beat per cycle,
// while out_stall is low, on the out_valid/out_stall channel, with last
// marking the final beat of that byte. The loader first waits for the request
// word 0xdeadbeef^1 (little endian, echoing any other word), answers with the
// ACK word, then takes and echoes an 8-byte image size, turns each image byte
// into one memory write at load_base plus the running offset, and finally
// checks a 4-byte trailer, answering ACK plus a good status or 0x50505050 plus
// a bad status. Bytes that arrive after the status are dropped until reset.
// A byte that only adds to a word being gathered causes no beat; an image
// byte causes one beat, a completed handshake word four, the size eight and
// the trailer five. The emitter walks the pending beats into the output
// register; the decoder takes the next byte in the same cycle the last beat
// of the current one moves out. Write load_base only while idle.
module uart_image_loader_handshake_top #(
  parameter int ADDR_WIDTH = uil_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // load base register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] load_base,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] write_addr,
  output logic [7:0]  write_data,
  output logic        load_ok,
  output logic        last
);

  logic [31:0]     base_addr;
  uil_pkg::burst_t burst;
  logic            bvalid;
  logic            btake;

  // the register write is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= uil_pkg::LOAD_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_addr <= load_base;
    end
  end

  // decode: track the phase, gather words, and register one burst per byte that causes beats
  uil_decode #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .base_addr(base_addr),
    .burst    (burst),
    .bvalid   (bvalid),
    .btake    (btake)
  );

  // emit: step through the burst, one beat into the output register per cycle while not stalled
  uil_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .bvalid    (bvalid),
    .btake     (btake),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .write_addr(write_addr),
    .write_data(write_data),
    .load_ok   (load_ok),
    .last      (last)
  );

endmodule

@@ hdl/uil_decode.sv @@
module uil_decode #(
  parameter int ADDR_WIDTH = uil_pkg::ADDR_WIDTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  input  logic [31:0]     base_addr,
  output uil_pkg::burst_t burst,
  output logic            bvalid,
  input  logic            btake
);

  typedef enum logic [2:0] {
    PH_HANDSHAKE,
    PH_SIZE,
    PH_IMAGE,
    PH_TRAILER,
    PH_DONE
  } phase_t;

  phase_t          phase, phase_next;
  logic [2:0]      pos, pos_next;
  logic [63:0]     gather, gather_next;
  logic [63:0]     size, size_next;
  logic [63:0]     loaded, loaded_next;
  uil_pkg::burst_t burst_next;
  logic            has_burst;
  logic            accept;
  logic [31:0]     word;
  logic [63:0]     size_word;
  logic [63:0]     loaded_inc;
  logic [ADDR_WIDTH-1:0] addr_sum;

  assign in_stall = bvalid && !btake;
  assign accept   = in_valid && !in_stall;

  assign word       = {rx_byte, gather[23:0]};
  assign size_word  = {rx_byte, gather[55:0]};
  assign loaded_inc = loaded + 64'd1;
  assign addr_sum   = ADDR_WIDTH'(base_addr) + ADDR_WIDTH'(loaded);

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    gather_next = gather | (64'(rx_byte) << {pos, 3'b000});
    size_next   = size;
    loaded_next = loaded;
    has_burst   = 1'b0;
    burst_next  = '{mode: uil_pkg::BM_WORD, data: 64'd0, addr: 32'd0, ok: 1'b0};
    unique case (phase)
      PH_HANDSHAKE, PH_TRAILER: begin
        pos_next = pos + 3'd1;
        if (pos == 3'd3) begin
          pos_next    = 3'd0;
          gather_next = 64'd0;
          has_burst   = 1'b1;
          if (phase == PH_HANDSHAKE) begin
            if (word == uil_pkg::REQ_WORD) begin
              burst_next.data = 64'(uil_pkg::ACK_WORD);
              phase_next      = PH_SIZE;
            end else begin
              burst_next.data = 64'(word);
            end
          end else begin
            burst_next.mode = uil_pkg::BM_STATUS;
            burst_next.ok   = (word == uil_pkg::MAGIC_WORD);
            burst_next.data = (word == uil_pkg::MAGIC_WORD) ? 64'(uil_pkg::ACK_WORD)
                                                             : 64'(uil_pkg::FAIL_WORD);
            phase_next      = PH_DONE;
          end
        end
      end
      PH_SIZE: begin
        pos_next = pos + 3'd1;
        if (pos == 3'd7) begin
          gather_next     = 64'd0;
          size_next       = size_word;
          loaded_next     = 64'd0;
          has_burst       = 1'b1;
          burst_next.mode = uil_pkg::BM_SIZE;
          burst_next.data = size_word;
          phase_next      = (size_word == 64'd0) ? PH_TRAILER : PH_IMAGE;
        end
      end
      PH_IMAGE: begin
        gather_next     = gather;
        has_burst       = 1'b1;
        burst_next.mode = uil_pkg::BM_WRITE;
        burst_next.addr = 32'(addr_sum);
        burst_next.data = 64'(rx_byte);
        loaded_next     = loaded_inc;
        if (loaded_inc == size) begin
          phase_next = PH_TRAILER;
        end
      end
      PH_DONE: begin
        gather_next = gather;
      end
      default: begin
        gather_next = gather;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HANDSHAKE;
      pos    <= 3'd0;
      gather <= 64'd0;
      size   <= 64'd0;
      loaded <= 64'd0;
      bvalid <= 1'b0;
    end else begin
      if (accept) begin
        phase  <= phase_next;
        pos    <= pos_next;
        gather <= gather_next;
        size   <= size_next;
        loaded <= loaded_next;
      end
      if (accept && has_burst) begin
        bvalid <= 1'b1;
      end else if (btake) begin
        bvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_burst) begin
      burst <= burst_next;
    end
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("loader left the done phase");

  a_word_pos: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_HANDSHAKE) || (phase == PH_TRAILER) || (phase == PH_IMAGE)) |-> (pos < 3'd4))
    else $error("word byte position out of range");

  a_image_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IMAGE) |-> (loaded < size))
    else $error("image byte count passed the image size");

endmodule

@@ hdl/uil_emit.sv @@
module uil_emit (
  input  logic            clk,
  input  logic            rst,
  input  uil_pkg::burst_t burst,
  input  logic            bvalid,
  output logic            btake,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      tx_byte,
  output logic [31:0]     write_addr,
  output logic [7:0]      write_data,
  output logic            load_ok,
  output logic            last
);

  logic [3:0]  idx;
  logic        load;
  logic [7:0]  sel_byte;
  logic [1:0]  res_kind;
  logic [7:0]  res_tx;
  logic [31:0] res_addr;
  logic [7:0]  res_data;
  logic        res_ok;
  logic        res_last;

  assign sel_byte = 8'(burst.data >> {idx[2:0], 3'b000});

  always_comb begin
    res_kind = uil_pkg::KIND_TX;
    res_tx   = sel_byte;
    res_addr = 32'd0;
    res_data = 8'd0;
    res_ok   = 1'b0;
    res_last = 1'b0;
    unique case (burst.mode)
      uil_pkg::BM_WORD: begin
        res_last = (idx == 4'd3);
      end
      uil_pkg::BM_SIZE: begin
        res_last = (idx == 4'd7);
      end
      uil_pkg::BM_WRITE: begin
        res_kind = uil_pkg::KIND_WRITE;
        res_tx   = 8'd0;
        res_addr = burst.addr;
        res_data = 8'(burst.data);
        res_last = 1'b1;
      end
      uil_pkg::BM_STATUS: begin
        if (idx == 4'd4) begin
          res_kind = uil_pkg::KIND_STATUS;
          res_tx   = 8'd0;
          res_ok   = burst.ok;
          res_last = 1'b1;
        end
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  // advance only when the output register is free or being drained
  assign load  = bvalid && (!out_valid || !out_stall);
  assign btake = load && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= res_last ? 4'd0 : idx + 4'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= res_kind;
      tx_byte    <= res_tx;
      write_addr <= res_addr;
      write_data <= res_data;
      load_ok    <= res_ok;
      last       <= res_last;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= 4'd7)
    else $error("burst index out of range");

  a_take_rewinds: assert property (@(posedge clk) disable iff (rst)
    btake |=> (idx == 4'd0))
    else $error("burst index not rewound after the last beat");

  a_write_single: assert property (@(posedge clk) disable iff (rst)
    (bvalid && (burst.mode == uil_pkg::BM_WRITE)) |-> (idx == 4'd0))
    else $error("memory write burst longer than one beat");

endmodule
